### sv/nearest_landmark_color_association_macros.svh
// assertion macros for the checker file of the landmark association block
`ifndef NEAREST_LANDMARK_COLOR_ASSOCIATION_MACROS_SVH
`define NEAREST_LANDMARK_COLOR_ASSOCIATION_MACROS_SVH

// condition implies property in the same cycle
`define NLCA_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("nlca assertion failed");

// condition implies property in the following cycle
`define NLCA_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("nlca assertion failed");

`endif

### sv/nlca_pkg.sv
// package: types, constants and helpers of the landmark association block
package nlca_pkg;

   // defaults of the top level parameters
   localparam int MAX_ENTRIES_DEF = 256;
   localparam int COUNT_BITS_DEF  = 16;

   // field widths
   localparam int COORD_W    = 24;
   localparam int POINT_W    = 16;
   localparam int HEAD_W     = 15;
   localparam int DIST_W     = 48;
   localparam int THR_W      = 16;
   localparam int STATUS_W   = 3;
   localparam int TYPE_W     = 2;
   localparam int IDX_OUT_W  = 8;
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 56;

   // constant divider sizes
   localparam int DIV_W  = 31;
   localparam int DVSR_W = 6;

   // fixed point constants
   localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
   localparam logic [18:0] RAD_PER_UNIT = 19'd292818;
   localparam logic [15:0] FULL_TURN    = 16'd23040;
   localparam logic [15:0] THREE_QUARTER_TURN = 16'd17280;
   localparam logic [15:0] HALF_TURN    = 16'd11520;
   localparam logic [15:0] QUARTER_TURN = 16'd5760;
   localparam logic [15:0] EIGHTH_TURN  = 16'd2880;
   localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd512;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7fffff;
   localparam logic signed [COORD_W-1:0] COORD_MIN = -24'sh800000;

   // horner step indexes: sine uses steps 0..2, cosine 3..6
   localparam logic [2:0] SIN_LAST_STEP = 3'd2;
   localparam logic [2:0] COS_LAST_STEP = 3'd6;
   localparam logic [2:0] PROD_LAST     = 3'd4;

   // request codes; every other code classifies
   localparam logic [TYPE_W-1:0] REQ_OBSERVE_BLUE   = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_OBSERVE_YELLOW = 2'd1;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED, ST_UPDATED, ST_DROPPED, ST_YELLOW, ST_BLUE, ST_UNABLE
   } status_type;

   typedef enum logic [3:0] {
      ROT_IDLE, ROT_MUL_X, ROT_MUL_X2, ROT_DIV_START, ROT_DIV_WAIT,
      ROT_MUL_T, ROT_SIN, ROT_COS, ROT_PROD, ROT_SUM
   } rot_state_type;

   typedef enum logic [2:0] {
      CTL_IDLE, CTL_ROTATE, CTL_SCAN, CTL_FETCH, CTL_DECIDE
   } ctl_state_type;

   typedef struct packed {
      logic                       start;
      logic signed [POINT_W-1:0]  point_x;
      logic signed [POINT_W-1:0]  point_y;
      logic signed [COORD_W-1:0]  car_x;
      logic signed [COORD_W-1:0]  car_y;
      logic signed [HEAD_W-1:0]   heading;
   } rot_req_type;

   typedef struct packed {
      logic                       done;
      logic signed [COORD_W-1:0]  gx;
      logic signed [COORD_W-1:0]  gy;
   } rot_rsp_type;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [DVSR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIV_W-1:0]  quotient;
   } div_rsp_type;

   // taylor denominators for each horner step
   function automatic logic [DVSR_W-1:0] divisor_of(input logic [2:0] step);
      logic [DVSR_W-1:0] d;
      unique case (step)
         3'd0: d = 6'd42;
         3'd1: d = 6'd20;
         3'd2: d = 6'd6;
         3'd3: d = 6'd56;
         3'd4: d = 6'd30;
         3'd5: d = 6'd12;
         default: d = 6'd2;
      endcase
      return d;
   endfunction

   // round half up from q30 to q14
   function automatic logic [14:0] q30_to_q14(input logic [30:0] v);
      logic [31:0] w;
      w = {1'b0, v} + 32'h0000_8000;
      return w[30:16];
   endfunction

endpackage

### sv/nlca_ram.sv
// generic single write port ram with registered read
module nlca_ram #(
   parameter int WIDTH = 80,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/nlca_cdiv.sv
// constant divider by reciprocal multiply, quotient registered in the cycle after start
module nlca_cdiv import nlca_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic              done_ff;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [30:0]       recip;
   logic [5:0]        shift;
   logic [60:0]       prod;

   // reciprocal and shift per taylor denominator, exact for dividends below 2^30
   always_comb begin
      unique case (div_req.divisor)
         6'd42: begin
            recip = 31'd1636178018;
            shift = 6'd36;
         end
         6'd20: begin
            recip = 31'd1717986919;
            shift = 6'd35;
         end
         6'd6: begin
            recip = 31'd1431655766;
            shift = 6'd33;
         end
         6'd56: begin
            recip = 31'd1227133514;
            shift = 6'd36;
         end
         6'd30: begin
            recip = 31'd1145324613;
            shift = 6'd35;
         end
         6'd12: begin
            recip = 31'd1431655766;
            shift = 6'd34;
         end
         default: begin
            recip = 31'd1073741824;
            shift = 6'd31;
         end
      endcase
      prod   = {31'b0, div_req.dividend[29:0]} * {30'b0, recip};
      quo_in = DIV_W'(prod >> shift);
   end

   // done flag
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= div_req.start;
      end
   end

   // quotient register
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         quo_ff <= quo_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

### sv/nlca_rotate.sv
// sine/cosine sequencer and rotation of the local point into the global frame
module nlca_rotate import nlca_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  rot_req_type rot_req,
   output rot_rsp_type rot_rsp
);

   rot_state_type state_ff, state_in;

   logic signed [POINT_W-1:0] lx_ff, ly_ff;
   logic signed [COORD_W-1:0] cx_ff, cy_ff;
   logic [1:0]         quad_ff, quad_in;
   logic               swap_ff, swap_in;
   logic [11:0]        ang_ff, ang_in;
   logic [29:0]        x_ff, x2_ff;
   logic [30:0]        t_ff, m_ff;
   logic [2:0]         step_ff;
   logic [2:0]         pk_ff;
   logic [14:0]        s_oct_ff;
   logic signed [15:0] sin_ff, cos_ff, sin_in, cos_in;
   logic signed [31:0] prod_ff;
   logic signed [32:0] sx_ff, sy_ff;
   logic               done_ff;
   logic signed [COORD_W-1:0] gx_ff, gy_ff;

   logic [15:0]        hm, rr;
   logic [14:0]        c_oct, ps, pc;
   logic [31:0]        mul_a, mul_b;
   logic [63:0]        mul_p;
   logic signed [15:0] sm_a, sm_b;
   logic signed [31:0] sm_p;

   div_req_type div_req;
   div_rsp_type div_rsp;

   // saturating add of the rounded rotation sum to the car position
   function automatic logic signed [COORD_W-1:0] sat_add(
      input logic signed [COORD_W-1:0] base,
      input logic signed [32:0]        acc
   );
      logic signed [32:0] r;
      logic [24:0]        v;
      r = (acc + 33'sd8192) >>> 14;
      v = {base[COORD_W-1], base} + r[24:0];
      if (v[24] != v[23]) begin
         return v[24] ? COORD_MIN : COORD_MAX;
      end
      return $signed(v[23:0]);
   endfunction

   nlca_cdiv u_cdiv (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // heading reduced to quadrant and octant angle
   always_comb begin
      hm = rot_req.heading[HEAD_W-1]
         ? ({rot_req.heading[HEAD_W-1], rot_req.heading} + FULL_TURN)
         : {1'b0, rot_req.heading};
      priority if (hm >= THREE_QUARTER_TURN) begin
         quad_in = 2'd3;
         rr      = hm - THREE_QUARTER_TURN;
      end else if (hm >= HALF_TURN) begin
         quad_in = 2'd2;
         rr      = hm - HALF_TURN;
      end else if (hm >= QUARTER_TURN) begin
         quad_in = 2'd1;
         rr      = hm - QUARTER_TURN;
      end else begin
         quad_in = 2'd0;
         rr      = hm;
      end
      swap_in = rr > EIGHTH_TURN;
      ang_in  = swap_in ? 12'(QUARTER_TURN - rr) : 12'(rr);
   end

   // shared unsigned multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ROT_MUL_X: begin
            mul_a = {20'b0, ang_ff};
            mul_b = {13'b0, RAD_PER_UNIT};
         end
         ROT_MUL_X2: begin
            mul_a = {2'b0, x_ff};
            mul_b = {2'b0, x_ff};
         end
         ROT_MUL_T: begin
            mul_a = {2'b0, x2_ff};
            mul_b = {1'b0, t_ff};
         end
         ROT_SIN: begin
            mul_a = {2'b0, x_ff};
            mul_b = {1'b0, t_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   // signed rotation multiplier, four products in turn
   always_comb begin
      unique case (pk_ff)
         3'd0: begin
            sm_a = ly_ff;
            sm_b = cos_ff;
         end
         3'd1: begin
            sm_a = lx_ff;
            sm_b = sin_ff;
         end
         3'd2: begin
            sm_a = ly_ff;
            sm_b = sin_ff;
         end
         default: begin
            sm_a = lx_ff;
            sm_b = cos_ff;
         end
      endcase
      sm_p = sm_a * sm_b;
   end

   // octant values mapped to the quadrant
   always_comb begin
      c_oct = q30_to_q14(t_ff);
      ps    = swap_ff ? c_oct : s_oct_ff;
      pc    = swap_ff ? s_oct_ff : c_oct;
      unique case (quad_ff)
         2'd0: begin
            sin_in = $signed({1'b0, ps});
            cos_in = $signed({1'b0, pc});
         end
         2'd1: begin
            sin_in = $signed({1'b0, pc});
            cos_in = -$signed({1'b0, ps});
         end
         2'd2: begin
            sin_in = -$signed({1'b0, ps});
            cos_in = -$signed({1'b0, pc});
         end
         default: begin
            sin_in = -$signed({1'b0, pc});
            cos_in = $signed({1'b0, ps});
         end
      endcase
   end

   // next state and divider launch
   always_comb begin
      state_in         = state_ff;
      div_req.start    = 1'b0;
      div_req.dividend = m_ff;
      div_req.divisor  = divisor_of(step_ff);
      unique case (state_ff)
         ROT_IDLE: begin
            if (rot_req.start) begin
               state_in = ROT_MUL_X;
            end
         end
         ROT_MUL_X:  state_in = ROT_MUL_X2;
         ROT_MUL_X2: state_in = ROT_DIV_START;
         ROT_DIV_START: begin
            div_req.start = 1'b1;
            state_in      = ROT_DIV_WAIT;
         end
         ROT_DIV_WAIT: begin
            if (div_rsp.done) begin
               priority if (step_ff == SIN_LAST_STEP) begin
                  state_in = ROT_SIN;
               end else if (step_ff == COS_LAST_STEP) begin
                  state_in = ROT_COS;
               end else begin
                  state_in = ROT_MUL_T;
               end
            end
         end
         ROT_MUL_T: state_in = ROT_DIV_START;
         ROT_SIN:   state_in = ROT_DIV_START;
         ROT_COS:   state_in = ROT_PROD;
         ROT_PROD: begin
            if (pk_ff == PROD_LAST) begin
               state_in = ROT_SUM;
            end
         end
         ROT_SUM:   state_in = ROT_IDLE;
         default:   state_in = ROT_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ROT_IDLE;
         done_ff  <= 1'b0;
         step_ff  <= '0;
         pk_ff    <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= state_ff == ROT_SUM;
         if (state_ff == ROT_MUL_X2) begin
            step_ff <= '0;
         end else if ((state_ff == ROT_DIV_WAIT && div_rsp.done && step_ff != SIN_LAST_STEP
                       && step_ff != COS_LAST_STEP) || state_ff == ROT_SIN) begin
            step_ff <= step_ff + 1'b1;
         end
         if (state_ff == ROT_COS) begin
            pk_ff <= '0;
         end else if (state_ff == ROT_PROD) begin
            pk_ff <= pk_ff + 1'b1;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ROT_IDLE: begin
            lx_ff   <= rot_req.point_x;
            ly_ff   <= rot_req.point_y;
            cx_ff   <= rot_req.car_x;
            cy_ff   <= rot_req.car_y;
            quad_ff <= quad_in;
            swap_ff <= swap_in;
            ang_ff  <= ang_in;
         end
         ROT_MUL_X: x_ff <= mul_p[29:0];
         ROT_MUL_X2: begin
            x2_ff <= mul_p[59:30];
            m_ff  <= mul_p[60:30];
         end
         ROT_DIV_WAIT: begin
            if (div_rsp.done) begin
               t_ff <= Q30_ONE - div_rsp.quotient;
            end
         end
         ROT_MUL_T: m_ff <= mul_p[60:30];
         ROT_SIN: begin
            s_oct_ff <= q30_to_q14(mul_p[60:30]);
            m_ff     <= {1'b0, x2_ff};
         end
         ROT_COS: begin
            sin_ff <= sin_in;
            cos_ff <= cos_in;
         end
         ROT_PROD: begin
            prod_ff <= sm_p;
            unique case (pk_ff)
               3'd1:    sx_ff <= 33'(prod_ff);
               3'd2:    sx_ff <= sx_ff + 33'(prod_ff);
               3'd3:    sy_ff <= 33'(prod_ff);
               3'd4:    sy_ff <= sy_ff - 33'(prod_ff);
               default: sx_ff <= sx_ff;
            endcase
         end
         ROT_SUM: begin
            gx_ff <= sat_add(cx_ff, sx_ff);
            gy_ff <= sat_add(cy_ff, sy_ff);
         end
         default: x_ff <= x_ff;
      endcase
   end

   assign rot_rsp.done = done_ff;
   assign rot_rsp.gx   = gx_ff;
   assign rot_rsp.gy   = gy_ff;

endmodule

### sv/nearest_landmark_color_association.sv
// top level: landmark table in one ram, nearest entry scan and colour update
//
// channel   dir  handshake            payload
// req       in   req_tvalid/tready    tdata point/car/heading, tuser request type
// rsp       out  rsp_tvalid/tready    tdata index/distance, tuser status
// csr       in   csr_we               csr_wdata match threshold
//
// an item passes through the sine/cosine sequencer and rotation (seven reciprocal
// divisions), then the scan of the landmark ram and its pipeline drain, then
// fetch, update and idle.
// one item is in work at a time; the next is taken while a result waits.
// reset is synchronous; it empties the table at once, no clearing pass.
// a stalled result holds in the output register; the update stalls behind it.
module nearest_landmark_color_association import nlca_pkg::*; #(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
   parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // point_x[15:0] point_y[31:16] car_x[55:32] car_y[79:56] heading[94:80]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_type[1:0]
   input  logic [TYPE_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // entry_index[7:0] match_dist_sq[55:8]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // status[2:0]
   output logic [STATUS_W-1:0]   rsp_tuser,
   input  logic                  csr_we,
   input  logic [THR_W-1:0]      csr_wdata
);

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int TW = $clog2(MAX_ENTRIES + 1);
   localparam int DW = 2 * COORD_W + 2 * COUNT_BITS;
   localparam int SQ_W = 2 * COORD_W;
   localparam int D_W  = SQ_W + 1;

   ctl_state_type state_ff, state_in;

   logic [TYPE_W-1:0]  req_type_ff;
   logic signed [COORD_W-1:0] gx_ff, gy_ff;
   logic [TW-1:0]      total_ff;
   logic [THR_W-1:0]   thr_ff;
   logic [2*THR_W-1:0] thr_sq_ff;
   logic [TW-1:0]      scan_cnt_ff;

   logic               p0_v_ff, p1_v_ff, p2_v_ff, p3_v_ff;
   logic [AW-1:0]      p0_idx_ff, p1_idx_ff, p2_idx_ff, p3_idx_ff;
   logic signed [COORD_W:0] dx_ff, dy_ff;
   logic signed [2*COORD_W+1:0] sqx_full, sqy_full;
   logic [SQ_W-1:0]    sqx_ff, sqy_ff;
   logic [D_W-1:0]     d_ff;
   logic               found_ff;
   logic [D_W-1:0]     best_d_ff;
   logic [AW-1:0]      best_idx_ff;

   logic               rsp_valid_ff;
   status_type         rsp_status_ff, status_in;
   logic [IDX_OUT_W-1:0] rsp_idx_ff, idx_out;
   logic [DIST_W-1:0]  rsp_dist_ff, dist_out;

   rot_req_type        rot_req;
   rot_rsp_type        rot_rsp;

   logic               scan_issue;
   logic               out_free;
   logic               load_rsp;
   logic               wr_en;
   logic [AW-1:0]      wr_addr, rd_addr, idx_sel;
   logic [DW-1:0]      wr_data, rd_data;
   logic [AW+IDX_OUT_W-1:0] idx_ext;
   logic signed [COORD_W-1:0] ex, ey;
   logic [COUNT_BITS-1:0] yc, bc, yc_next, bc_next;
   logic               observe, far, full, insert;

   // rotation request straight from the input word
   always_comb begin
      rot_req.start   = req_tvalid && req_tready;
      rot_req.point_x = $signed(req_tdata[15:0]);
      rot_req.point_y = $signed(req_tdata[31:16]);
      rot_req.car_x   = $signed(req_tdata[55:32]);
      rot_req.car_y   = $signed(req_tdata[79:56]);
      rot_req.heading = $signed(req_tdata[94:80]);
   end

   nlca_rotate u_rotate (
      .clock   (clock),
      .reset   (reset),
      .rot_req (rot_req),
      .rot_rsp (rot_rsp)
   );

   nlca_ram #(
      .WIDTH (DW),
      .DEPTH (MAX_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ram word fields
   always_comb begin
      ex = $signed(rd_data[COORD_W-1:0]);
      ey = $signed(rd_data[2*COORD_W-1:COORD_W]);
      yc = rd_data[2*COORD_W +: COUNT_BITS];
      bc = rd_data[2*COORD_W+COUNT_BITS +: COUNT_BITS];
      yc_next = (req_type_ff == REQ_OBSERVE_YELLOW && yc != '1) ? yc + 1'b1 : yc;
      bc_next = (req_type_ff == REQ_OBSERVE_BLUE && bc != '1) ? bc + 1'b1 : bc;
   end

   // decision on the nearest entry
   always_comb begin
      observe = req_type_ff == REQ_OBSERVE_BLUE || req_type_ff == REQ_OBSERVE_YELLOW;
      far     = !found_ff || best_d_ff > D_W'(thr_sq_ff);
      full    = total_ff == TW'(MAX_ENTRIES);
      insert  = observe && far && !full;
      idx_sel = best_idx_ff;
      if (observe) begin
         priority if (far && !full) begin
            status_in = ST_INSERTED;
            idx_sel   = total_ff[AW-1:0];
         end else if (far) begin
            status_in = ST_DROPPED;
            idx_sel   = '0;
         end else begin
            status_in = ST_UPDATED;
         end
      end else begin
         priority if (!found_ff) begin
            status_in = ST_UNABLE;
            idx_sel   = '0;
         end else if (bc > yc) begin
            status_in = ST_BLUE;
         end else if (bc < yc) begin
            status_in = ST_YELLOW;
         end else begin
            status_in = ST_UNABLE;
         end
      end
      idx_ext  = {{IDX_OUT_W{1'b0}}, idx_sel};
      idx_out  = idx_ext[IDX_OUT_W-1:0];
      dist_out = (!found_ff || best_d_ff[D_W-1]) ? '1 : best_d_ff[DIST_W-1:0];
   end

   // next state, ram access
   always_comb begin
      state_in   = state_ff;
      out_free   = !rsp_valid_ff || rsp_tready;
      scan_issue = state_ff == CTL_SCAN && scan_cnt_ff < total_ff;
      load_rsp   = 1'b0;
      rd_addr    = (state_ff == CTL_SCAN) ? scan_cnt_ff[AW-1:0] : best_idx_ff;
      wr_en      = 1'b0;
      wr_addr    = idx_sel;
      wr_data    = insert ? {{(2*COUNT_BITS){1'b0}}, gy_ff, gx_ff}
                          : {bc_next, yc_next, gy_ff, gx_ff};
      unique case (state_ff)
         CTL_IDLE: begin
            if (req_tvalid) begin
               state_in = CTL_ROTATE;
            end
         end
         CTL_ROTATE: begin
            if (rot_rsp.done) begin
               state_in = CTL_SCAN;
            end
         end
         CTL_SCAN: begin
            if (!scan_issue && !p0_v_ff && !p1_v_ff && !p2_v_ff && !p3_v_ff) begin
               state_in = CTL_FETCH;
            end
         end
         CTL_FETCH: state_in = CTL_DECIDE;
         CTL_DECIDE: begin
            if (out_free) begin
               load_rsp = 1'b1;
               wr_en    = observe && (!far || !full);
               state_in = CTL_IDLE;
            end
         end
         default: state_in = CTL_IDLE;
      endcase
   end

   assign req_tready = state_ff == CTL_IDLE;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTL_IDLE;
         total_ff     <= '0;
         thr_ff       <= THRESHOLD_RESET;
         scan_cnt_ff  <= '0;
         found_ff     <= 1'b0;
         p0_v_ff      <= 1'b0;
         p1_v_ff      <= 1'b0;
         p2_v_ff      <= 1'b0;
         p3_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            thr_ff <= csr_wdata;
         end
         if (state_ff == CTL_ROTATE) begin
            scan_cnt_ff <= '0;
            found_ff    <= 1'b0;
         end else begin
            if (scan_issue) begin
               scan_cnt_ff <= scan_cnt_ff + 1'b1;
            end
            if (p3_v_ff) begin
               found_ff <= 1'b1;
            end
         end
         p0_v_ff <= scan_issue;
         p1_v_ff <= p0_v_ff;
         p2_v_ff <= p1_v_ff;
         p3_v_ff <= p2_v_ff;
         if (load_rsp && insert) begin
            total_ff <= total_ff + 1'b1;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // squares of the distance components
   always_comb begin
      sqx_full = dx_ff * dx_ff;
      sqy_full = dy_ff * dy_ff;
   end

   // scan pipeline and result payload
   always_ff @(posedge clock) begin
      thr_sq_ff <= thr_ff * thr_ff;
      if (req_tvalid && req_tready) begin
         req_type_ff <= req_tuser;
      end
      if (rot_rsp.done) begin
         gx_ff <= rot_rsp.gx;
         gy_ff <= rot_rsp.gy;
      end
      p0_idx_ff <= scan_cnt_ff[AW-1:0];
      p1_idx_ff <= p0_idx_ff;
      dx_ff     <= {ex[COORD_W-1], ex} - {gx_ff[COORD_W-1], gx_ff};
      dy_ff     <= {ey[COORD_W-1], ey} - {gy_ff[COORD_W-1], gy_ff};
      p2_idx_ff <= p1_idx_ff;
      sqx_ff    <= sqx_full[SQ_W-1:0];
      sqy_ff    <= sqy_full[SQ_W-1:0];
      p3_idx_ff <= p2_idx_ff;
      d_ff      <= {1'b0, sqx_ff} + {1'b0, sqy_ff};
      if (p3_v_ff && (!found_ff || d_ff < best_d_ff)) begin
         best_d_ff   <= d_ff;
         best_idx_ff <= p3_idx_ff;
      end
      if (load_rsp) begin
         rsp_status_ff <= status_in;
         rsp_idx_ff    <= idx_out;
         rsp_dist_ff   <= dist_out;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_dist_ff, rsp_idx_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

### sv/nlca_checker.sv
// port checker of the landmark association block and its bind
`include "nearest_landmark_color_association_macros.svh"

module nlca_checker import nlca_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic [TYPE_W-1:0]     req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [STATUS_W-1:0]   rsp_tuser,
   input logic                  csr_we,
   input logic [THR_W-1:0]      csr_wdata
);

   // a stalled result word holds
   `NLCA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // one item at a time: busy right after an accepted word
   `NLCA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)

   // only defined status codes leave the block
   `NLCA_ASSERT_NOW(a_status_range, clock, reset, rsp_tvalid, rsp_tuser <= ST_UNABLE)

   // a dropped insert reports index zero
   `NLCA_ASSERT_NOW(a_drop_index, clock, reset, rsp_tvalid && rsp_tuser == ST_DROPPED, rsp_tdata[7:0] == 8'd0)

endmodule

bind nearest_landmark_color_association nlca_checker u_nlca_checker (.*);
